@@ hdl/two_sum_pair_query_table_defines.svh @@
// Assertion macros shared by the checker file.
`ifndef TWO_SUM_PAIR_QUERY_TABLE_DEFINES_SVH
`define TWO_SUM_PAIR_QUERY_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsq assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsq assertion failed");

`endif

@@ hdl/tsq_pkg.sv @@
`default_nettype none

package tsq_pkg;

	// command codes on the input word
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	// fixed width of the operand port
	localparam int OPERAND_W = 32;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;      // sorted insert of the new value
		logic load;     // copy table into the walk chains
		logic shift_a;  // low pointer advances
		logic shift_b;  // high pointer retreats
	} cell_ctrl_t;

	// where a cell sits relative to the current fill
	typedef struct packed {
		logic l_occ;    // holds an entry of the low-aligned table
		logic l_new;    // next free slot of the low-aligned table
		logic r_occ;    // holds an entry of the high-aligned table
		logic r_new;    // next free slot of the high-aligned table
	} cell_pos_t;

endpackage

`default_nettype wire

@@ hdl/two_sum_pair_query_table.sv @@
`default_nettype none

// Sorted multiset of signed values with a two-sum query. cmd 0 adds operand
// (low VALUE_WIDTH bits, sign-extended) through a chain of TABLE_DEPTH
// cells that all compare and shift in parallel; a word arriving at a full
// table is dropped and answered with rejected = 1. cmd 1 asks whether two
// distinct entries sum to operand: the table is copied into two walk chains
// whose ends present the low and high entries, and one pointer moves per
// cycle until a match or until the pointers meet. One word is in flight at
// a time: in_ready is high only when the block is idle, while a finished
// result may still sit in the output register waiting for out_ready; the
// next result then waits for that register to empty.
module two_sum_pair_query_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              cmd,
	input  wire logic signed [tsq_pkg::OPERAND_W-1:0] operand,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             pair_found,
	output logic                             rejected
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_POST
	} state_t;

	state_t                         state_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  gap_q;
	logic signed [VALUE_WIDTH:0]    target_q;
	logic                           res_found_q;
	logic                           res_rej_q;
	logic                           out_valid_q;
	logic                           pair_found_q;
	logic                           rejected_q;

	logic                           accept;
	logic                           full;
	logic signed [VALUE_WIDTH-1:0]  ins_value;
	logic signed [VALUE_WIDTH:0]    sum;
	logic                           hit;
	logic                           over;
	tsq_pkg::cell_ctrl_t            ctrl;

	logic signed [VALUE_WIDTH-1:0]  l_val  [TABLE_DEPTH];
	logic                           l_gt   [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0]  r_val  [TABLE_DEPTH];
	logic                           r_le   [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0]  a_val  [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0]  b_val  [TABLE_DEPTH];

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign full       = (count_q == CW'(TABLE_DEPTH));
	assign ins_value  = operand[VALUE_WIDTH-1:0];
	assign out_valid  = out_valid_q;
	assign pair_found = pair_found_q;
	assign rejected   = rejected_q;

	// low entry sits at cell 0 of chain a, high entry at the top of chain b
	assign sum  = {a_val[0][VALUE_WIDTH-1], a_val[0]}
	            + {b_val[TABLE_DEPTH-1][VALUE_WIDTH-1], b_val[TABLE_DEPTH-1]};
	assign hit  = (sum == target_q);
	assign over = (sum > target_q);

	// command to the cell row
	always_comb begin
		ctrl.ins     = accept && (cmd == tsq_pkg::CMD_ADD) && !full;
		ctrl.load    = accept && (cmd == tsq_pkg::CMD_FIND);
		ctrl.shift_a = (state_q == ST_WALK) && !hit && !over;
		ctrl.shift_b = (state_q == ST_WALK) && !hit && over;
	end

	// cell row
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tsq_pkg::cell_pos_t             pos;
		logic signed [VALUE_WIDTH-1:0]  l_prev;
		logic                           l_prev_gt;
		logic signed [VALUE_WIDTH-1:0]  r_next;
		logic                           r_next_le;
		logic signed [VALUE_WIDTH-1:0]  a_next;
		logic signed [VALUE_WIDTH-1:0]  b_prev;

		always_comb begin
			pos.l_occ = (CW'(i) < count_q);
			pos.l_new = (CW'(i) == count_q);
			pos.r_occ = (CW'(TABLE_DEPTH - i) <= count_q);
			pos.r_new = (CW'(TABLE_DEPTH - 1 - i) == count_q);
		end

		if (i == 0) begin : g_bot
			assign l_prev    = '0;
			assign l_prev_gt = 1'b0;
			assign b_prev    = '0;
		end else begin : g_bot
			assign l_prev    = l_val[i-1];
			assign l_prev_gt = l_gt[i-1];
			assign b_prev    = b_val[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_top
			assign r_next    = '0;
			assign r_next_le = 1'b0;
			assign a_next    = '0;
		end else begin : g_top
			assign r_next    = r_val[i+1];
			assign r_next_le = r_le[i+1];
			assign a_next    = a_val[i+1];
		end

		tsq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.pos       (pos),
			.ins_value (ins_value),
			.l_prev    (l_prev),
			.l_prev_gt (l_prev_gt),
			.r_next    (r_next),
			.r_next_le (r_next_le),
			.a_next    (a_next),
			.b_prev    (b_prev),
			.l_val     (l_val[i]),
			.l_gt      (l_gt[i]),
			.r_val     (r_val[i]),
			.r_le      (r_le[i]),
			.a_val     (a_val[i]),
			.b_val     (b_val[i])
		);
	end

	// sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			gap_q        <= '0;
			target_q     <= '0;
			res_found_q  <= 1'b0;
			res_rej_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			pair_found_q <= 1'b0;
			rejected_q   <= 1'b0;
		end else begin
			// the post state refills the output register itself
			if (out_valid_q && out_ready && (state_q != ST_POST)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_found_q <= 1'b0;
						if (cmd == tsq_pkg::CMD_ADD) begin
							res_rej_q <= full;
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= ST_POST;
						end else begin
							res_rej_q <= 1'b0;
							target_q  <= {ins_value[VALUE_WIDTH-1], ins_value};
							gap_q     <= count_q - CW'(1);
							state_q   <= (count_q < CW'(2)) ? ST_POST : ST_WALK;
						end
					end
				end
				ST_WALK: begin
					// one pointer step per cycle until match or pointers meet
					if (hit) begin
						res_found_q <= 1'b1;
						state_q     <= ST_POST;
					end else if (gap_q == CW'(1)) begin
						state_q <= ST_POST;
					end else begin
						gap_q <= gap_q - CW'(1);
					end
				end
				ST_POST: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						pair_found_q <= res_found_q;
						rejected_q   <= res_rej_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/tsq_cell.sv @@
`default_nettype none

// One slot of the sorted chain. Holds the entry of the low-aligned copy (l),
// of the high-aligned copy (r) and two walk registers used during a query.
module tsq_cell #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                            clk,
	input  wire tsq_pkg::cell_ctrl_t       ctrl,
	input  wire tsq_pkg::cell_pos_t        pos,
	input  wire logic signed [VALUE_WIDTH-1:0] ins_value,
	input  wire logic signed [VALUE_WIDTH-1:0] l_prev,
	input  wire                            l_prev_gt,
	input  wire logic signed [VALUE_WIDTH-1:0] r_next,
	input  wire                            r_next_le,
	input  wire logic signed [VALUE_WIDTH-1:0] a_next,
	input  wire logic signed [VALUE_WIDTH-1:0] b_prev,
	output logic signed [VALUE_WIDTH-1:0]  l_val,
	output logic                           l_gt,
	output logic signed [VALUE_WIDTH-1:0]  r_val,
	output logic                           r_le,
	output logic signed [VALUE_WIDTH-1:0]  a_val,
	output logic signed [VALUE_WIDTH-1:0]  b_val
);

	logic signed [VALUE_WIDTH-1:0] l_q;
	logic signed [VALUE_WIDTH-1:0] r_q;
	logic signed [VALUE_WIDTH-1:0] a_q;
	logic signed [VALUE_WIDTH-1:0] b_q;

	// entries above the new value move toward the top (low-aligned copy);
	// entries at or below it move toward the bottom (high-aligned copy)
	assign l_gt  = pos.l_occ && (l_q > ins_value);
	assign r_le  = pos.r_occ && (r_q <= ins_value);
	assign l_val = l_q;
	assign r_val = r_q;
	assign a_val = a_q;
	assign b_val = b_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (l_gt || pos.l_new) begin
				l_q <= l_prev_gt ? l_prev : ins_value;
			end
			if (r_le || pos.r_new) begin
				r_q <= r_next_le ? r_next : ins_value;
			end
		end
		// walk chains: a drains toward cell 0, b toward the top cell
		if (ctrl.load) begin
			a_q <= l_q;
			b_q <= r_q;
		end else begin
			if (ctrl.shift_a) begin
				a_q <= a_next;
			end
			if (ctrl.shift_b) begin
				b_q <= b_prev;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/tsq_checker.sv @@
`default_nettype none

`include "two_sum_pair_query_table_defines.svh"

// Port-level checks for the two-sum table.
module tsq_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire pair_found,
	input wire rejected
);

	// a stalled result word stays put
	`TSQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`TSQ_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(pair_found) && $stable(rejected))

	// one word in flight: taking a word closes the input for the next cycle
	`TSQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// a result answers either an add or a query, never both
	`TSQ_ASSERT_NOW(a_flags_exclusive, clk, arst_n, out_valid, !(pair_found && rejected))

endmodule

bind two_sum_pair_query_table tsq_checker u_tsq_checker (.*);

`default_nettype wire
